[hdl/skrf_pkg.sv]
// Shared types and constants for the scalar Kalman rate filter.
// No dependencies; used by every module of the block.
package skrf_pkg;

   localparam int RATE_W       = 32;
   localparam int VAR_W        = 32;
   localparam int GAIN_OUT_W   = 25;
   localparam int CSR_ADDR_W   = 4;
   localparam int CSR_DATA_W   = 32;
   localparam int GAIN_FRAC_BITS_DEF = 24;

   localparam logic [31:0] MEAS_NOISE_RST = 32'd167772;
   localparam logic [31:0] PROC_NOISE_RST = 32'd168;
   localparam logic [31:0] INIT_EST_RST   = 32'd0;
   localparam logic [31:0] INIT_VAR_RST   = 32'd16777216;

   typedef enum logic [1:0] {
      REG_MEAS_NOISE = 2'd0,
      REG_PROC_NOISE = 2'd1,
      REG_INIT_EST   = 2'd2,
      REG_INIT_VAR   = 2'd3
   } reg_idx_type;

   typedef struct packed {
      logic [31:0] meas_noise;
      logic [31:0] proc_noise;
      logic [31:0] init_est;
      logic [31:0] init_var;
   } cfg_type;

   typedef struct packed {
      logic accept;
      logic prep;
      logic prep2;
      logic div_step;
      logic div_first;
      logic mul_est;
      logic mul_var;
      logic finish;
   } cmd_type;

endpackage

[hdl/scalar_kalman_rate_filter_top.sv]
// An item is taken in idle, then passes through prep, prep2, the gain divide, the two multiplies
// and finish, after which rsp_valid rises; no new item is taken until it is through. The gain
// divider gives one quotient bit per cycle; a held result stalls only the next item's finish.
// Reset clears the sequencer, the output valid and the started flag, and loads the
// register defaults; the first item after reset takes its estimate and variance from them.
module scalar_kalman_rate_filter_top #(
   parameter int GAIN_FRAC_BITS = skrf_pkg::GAIN_FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [skrf_pkg::RATE_W-1:0]     req_raw_rate,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [skrf_pkg::RATE_W-1:0]     rsp_filtered_rate,
   output logic        [skrf_pkg::VAR_W-1:0]      rsp_error_variance,
   output logic        [skrf_pkg::GAIN_OUT_W-1:0] rsp_kalman_gain,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic        [skrf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic        [skrf_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic        [skrf_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                   csr_pready
);

   skrf_pkg::cfg_type cfg;
   skrf_pkg::cmd_type cmd;

   skrf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   skrf_ctrl #(
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   skrf_dpath #(
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .cfg                (cfg),
      .req_raw_rate       (req_raw_rate),
      .rsp_filtered_rate  (rsp_filtered_rate),
      .rsp_error_variance (rsp_error_variance),
      .rsp_kalman_gain    (rsp_kalman_gain)
   );

endmodule

[hdl/skrf_csr.sv]
// Configuration register file, APB-style write and read.
// Depends on skrf_pkg.
module skrf_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [skrf_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [skrf_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [skrf_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   output skrf_pkg::cfg_type                 cfg
);

   skrf_pkg::cfg_type     cfg_ff, cfg_in;
   skrf_pkg::reg_idx_type idx;
   logic                  wr_en;

   assign idx   = skrf_pkg::reg_idx_type'(csr_paddr[3:2]);
   assign wr_en = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            skrf_pkg::REG_MEAS_NOISE: cfg_in.meas_noise = csr_pwdata;
            skrf_pkg::REG_PROC_NOISE: cfg_in.proc_noise = csr_pwdata;
            skrf_pkg::REG_INIT_EST:   cfg_in.init_est   = csr_pwdata;
            skrf_pkg::REG_INIT_VAR:   cfg_in.init_var   = csr_pwdata;
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.meas_noise <= skrf_pkg::MEAS_NOISE_RST;
         cfg_ff.proc_noise <= skrf_pkg::PROC_NOISE_RST;
         cfg_ff.init_est   <= skrf_pkg::INIT_EST_RST;
         cfg_ff.init_var   <= skrf_pkg::INIT_VAR_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (idx)
         skrf_pkg::REG_MEAS_NOISE: csr_prdata = cfg_ff.meas_noise;
         skrf_pkg::REG_PROC_NOISE: csr_prdata = cfg_ff.proc_noise;
         skrf_pkg::REG_INIT_EST:   csr_prdata = cfg_ff.init_est;
         skrf_pkg::REG_INIT_VAR:   csr_prdata = cfg_ff.init_var;
         default:                  csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

endmodule

[hdl/skrf_ctrl.sv]
// Sequencer for one filter step: prepare, divide, two multiplies, finish.
// Depends on skrf_pkg; drives the datapath through cmd_type.
module skrf_ctrl #(
   parameter int GAIN_FRAC_BITS = skrf_pkg::GAIN_FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output skrf_pkg::cmd_type cmd
);

   localparam int CNT_W = $clog2(GAIN_FRAC_BITS + 1);

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_PREP    = 7'b0000010,
      ST_PREP2   = 7'b0000100,
      ST_DIV     = 7'b0001000,
      ST_MUL_EST = 7'b0010000,
      ST_MUL_VAR = 7'b0100000,
      ST_FINISH  = 7'b1000000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;
   logic             div_last;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign div_last = (cnt_ff == CNT_W'(GAIN_FRAC_BITS));

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_PREP2;
         end
         ST_PREP2: begin
            cmd.prep2 = 1'b1;
            cnt_in    = '0;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step  = 1'b1;
            cmd.div_first = (cnt_ff == '0);
            cnt_in        = cnt_ff + CNT_W'(1);
            if (div_last) begin
               state_in = ST_MUL_EST;
            end
         end
         ST_MUL_EST: begin
            cmd.mul_est = 1'b1;
            state_in    = ST_MUL_VAR;
         end
         ST_MUL_VAR: begin
            cmd.mul_var = 1'b1;
            state_in    = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the output register can take the item
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.finish || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[hdl/skrf_dpath.sv]
// Filter datapath: state registers, restoring divider for the gain,
// one shared multiplier, rounding and saturation, output registers.
// Depends on skrf_pkg; commanded by skrf_ctrl.
module skrf_dpath #(
   parameter int GAIN_FRAC_BITS = skrf_pkg::GAIN_FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  skrf_pkg::cmd_type                      cmd,
   input  skrf_pkg::cfg_type                      cfg,
   input  logic signed [skrf_pkg::RATE_W-1:0]     req_raw_rate,
   output logic signed [skrf_pkg::RATE_W-1:0]     rsp_filtered_rate,
   output logic        [skrf_pkg::VAR_W-1:0]      rsp_error_variance,
   output logic        [skrf_pkg::GAIN_OUT_W-1:0] rsp_kalman_gain
);

   localparam int G  = GAIN_FRAC_BITS;
   localparam int PW = 34 + G;
   localparam logic [G:0]    ONE  = {1'b1, {G{1'b0}}};
   localparam logic [PW-1:0] HALF = {{(PW-1){1'b0}}, 1'b1} << (G - 1);

   logic started_ff;
   logic [31:0] raw_ff, est_ff, var_ff, z_ff, pp_ff;
   logic [32:0] den_ff, mag_ff;
   logic        den_zero_ff, neg_ff;
   logic [33:0] rem_ff;
   logic [G:0]  q_ff;
   logic [PW-1:0] prod_ff;
   logic [31:0] out_rate_ff, out_var_ff;
   logic [skrf_pkg::GAIN_OUT_W-1:0] out_gain_ff;

   logic [32:0] neg_raw, pp_sum, diff, mag_in;
   logic [31:0] z_in, pp_in, est_new, var_new;
   logic [33:0] trial, rem_in;
   logic        ge;
   logic [G:0]  gain, mul_b;
   logic [32:0] mul_a;
   logic [PW-1:0] mul_p, rnd_p;
   logic [33:0] rnd_q;
   logic [35:0] est_ext, corr_ext, est_sum;
   logic [G+skrf_pkg::GAIN_OUT_W:0] gain_ext;

   // measurement: negated sample, most negative input saturates
   assign neg_raw = 33'd0 - {raw_ff[31], raw_ff};
   assign z_in    = (neg_raw[32] != neg_raw[31]) ? 32'h7FFF_FFFF : neg_raw[31:0];

   // predicted variance, saturating
   assign pp_sum = {1'b0, var_ff} + {1'b0, cfg.proc_noise};
   assign pp_in  = pp_sum[32] ? 32'hFFFF_FFFF : pp_sum[31:0];

   assign diff   = {z_ff[31], z_ff} - {est_ff[31], est_ff};
   assign mag_in = diff[32] ? (33'd0 - diff) : diff;

   // restoring division, one quotient bit per step; the top bit needs no shift
   assign trial  = cmd.div_first ? rem_ff : {rem_ff[32:0], 1'b0};
   assign ge     = (trial >= {1'b0, den_ff});
   assign rem_in = ge ? (trial - {1'b0, den_ff}) : trial;

   assign gain = den_zero_ff ? '0 : q_ff;

   assign mul_a = cmd.mul_est ? mag_ff : {1'b0, pp_ff};
   assign mul_b = cmd.mul_est ? gain : (ONE - gain);
   assign mul_p = mul_a * mul_b;

   assign rnd_p = prod_ff + HALF;
   assign rnd_q = rnd_p[PW-1:G];

   assign est_ext  = {{4{est_ff[31]}}, est_ff};
   assign corr_ext = {2'b00, rnd_q};
   assign est_sum  = neg_ff ? (est_ext - corr_ext) : (est_ext + corr_ext);

   always_comb begin
      if (est_sum[35:31] == 5'b00000 || est_sum[35:31] == 5'b11111) begin
         est_new = est_sum[31:0];
      end else if (est_sum[35]) begin
         est_new = 32'h8000_0000;
      end else begin
         est_new = 32'h7FFF_FFFF;
      end
   end

   assign var_new  = (|rnd_q[33:32]) ? 32'hFFFF_FFFF : rnd_q[31:0];
   assign gain_ext = {{skrf_pkg::GAIN_OUT_W{1'b0}}, gain};

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
      end else if (cmd.accept) begin
         started_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         raw_ff <= req_raw_rate;
         if (!started_ff) begin
            est_ff <= cfg.init_est;
            var_ff <= cfg.init_var;
         end
      end
      if (cmd.prep) begin
         z_ff  <= z_in;
         pp_ff <= pp_in;
      end
      if (cmd.prep2) begin
         den_ff      <= {1'b0, pp_ff} + {1'b0, cfg.meas_noise};
         den_zero_ff <= (pp_ff == '0) && (cfg.meas_noise == '0);
         rem_ff      <= {2'b00, pp_ff};
         neg_ff      <= diff[32];
         mag_ff      <= mag_in;
      end
      if (cmd.div_step) begin
         rem_ff <= rem_in;
         q_ff   <= {q_ff[G-1:0], ge};
      end
      if (cmd.mul_est || cmd.mul_var) begin
         prod_ff <= mul_p;
      end
      if (cmd.mul_var) begin
         est_ff <= est_new;
      end
      if (cmd.finish) begin
         var_ff      <= var_new;
         out_rate_ff <= est_ff;
         out_var_ff  <= var_new;
         out_gain_ff <= gain_ext[skrf_pkg::GAIN_OUT_W-1:0];
      end
   end

   assign rsp_filtered_rate  = out_rate_ff;
   assign rsp_error_variance = out_var_ff;
   assign rsp_kalman_gain    = out_gain_ff;

endmodule

[tb/sv/tb_scalar_kalman_rate_filter_top.sv]
`timescale 1ns / 1ps
// Testbench for scalar_kalman_rate_filter_top: a directed table, then random rate samples.
// Checked rows use the table's values; every other result is checked against an in-bench fixed-point Kalman predictor.
// Depends on skrf_pkg and the filter RTL.
module tb_scalar_kalman_rate_filter_top;

   localparam int GAIN_FRAC = skrf_pkg::GAIN_FRAC_BITS_DEF;
   localparam longint unsigned ONE_G = 64'd1 << GAIN_FRAC;
   localparam logic [skrf_pkg::GAIN_OUT_W-1:0] GAIN_ONE = skrf_pkg::GAIN_OUT_W'(ONE_G);
   localparam longint S32_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam longint S32_MIN = -64'sh0000_0000_8000_0000;
   localparam int RAND_PHASES = 8;
   localparam int ITEMS_PER_PHASE = 106;
   localparam int DIR_ROWS = 31;

   typedef struct packed {
      logic signed [skrf_pkg::RATE_W-1:0] rate;
      logic [skrf_pkg::VAR_W-1:0]         variance;
      logic [skrf_pkg::GAIN_OUT_W-1:0]    gain;
   } filt_out_type;

   typedef enum logic [1:0] {ROW_CSR, ROW_ITEM, ROW_CHECKED} row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      skrf_pkg::reg_idx_type idx;
      logic [31:0]           data;
      filt_out_type          want;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [skrf_pkg::RATE_W-1:0] req_raw_rate = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [skrf_pkg::RATE_W-1:0] rsp_filtered_rate;
   logic [skrf_pkg::VAR_W-1:0] rsp_error_variance;
   logic [skrf_pkg::GAIN_OUT_W-1:0] rsp_kalman_gain;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [skrf_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [skrf_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [skrf_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   // Filter state as the bench sees it
   skrf_pkg::cfg_type shadow_cfg;
   longint est_st;
   logic [skrf_pkg::VAR_W-1:0] pvar_st;
   bit started_st;
   filt_out_type rate_estimates_q[$];
   int fail_count = 0;
   int stall_left = 0;

   // Writes sit between items; expected values only where obvious (R = 0 tracks z exactly unless P and Q are zero too)
   dir_row_type dir_steps [DIR_ROWS] = '{
      '{ROW_CSR,     skrf_pkg::REG_MEAS_NOISE, 32'h0000_0000, '0},
      '{ROW_CSR,     skrf_pkg::REG_PROC_NOISE, 32'h0000_0000, '0},
      '{ROW_CSR,     skrf_pkg::REG_INIT_EST,   32'h8000_0000, '0},
      '{ROW_CSR,     skrf_pkg::REG_INIT_VAR,   32'hFFFF_FFFF, '0},
      '{ROW_CHECKED, skrf_pkg::REG_MEAS_NOISE, 32'h8000_0000,
        '{32'sh7FFF_FFFF, 32'h0, GAIN_ONE}},
      '{ROW_CHECKED, skrf_pkg::REG_MEAS_NOISE, 32'h7FFF_FFFF,
        '{32'sh7FFF_FFFF, 32'h0, '0}},
      '{ROW_CSR,     skrf_pkg::REG_PROC_NOISE, 32'hFFFF_FFFF, '0},
      '{ROW_CHECKED, skrf_pkg::REG_MEAS_NOISE, 32'h7FFF_FFFF,
        '{32'sh8000_0001, 32'h0, GAIN_ONE}},
      '{ROW_CHECKED, skrf_pkg::REG_MEAS_NOISE, 32'hFFFF_FFFF,
        '{32'sh0000_0001, 32'h0, GAIN_ONE}},
      '{ROW_CSR,     skrf_pkg::REG_MEAS_NOISE, 32'hFFFF_FFFF, '0},
      '{ROW_ITEM,    skrf_pkg::REG_MEAS_NOISE, 32'h0000_0000, '0},
      '{ROW_ITEM,    skrf_pkg::REG_MEAS_NOISE, 32'h1234_5678, '0},
      '{ROW_CSR,     skrf_pkg::REG_INIT_EST,   32'h7FFF_FFFF, '0},
      '{ROW_CSR,     skrf_pkg::REG_INIT_VAR,   32'h0000_0000, '0},
      '{ROW_CSR,     skrf_pkg::REG_MEAS_NOISE, 32'h0000_0000, '0},
      '{ROW_CHECKED, skrf_pkg::REG_MEAS_NOISE, 32'h0000_0005,
        '{32'shFFFF_FFFB, 32'h0, GAIN_ONE}},
      '{ROW_CSR,     skrf_pkg::REG_PROC_NOISE, 32'h0000_0003, '0},
      '{ROW_CSR,     skrf_pkg::REG_MEAS_NOISE, 32'h0000_0003, '0},
      '{ROW_ITEM,    skrf_pkg::REG_MEAS_NOISE, 32'h0000_0004, '0},
      '{ROW_CSR,     skrf_pkg::REG_MEAS_NOISE, 32'h0000_0000, '0},
      '{ROW_CHECKED, skrf_pkg::REG_MEAS_NOISE, 32'h0000_0000,
        '{32'sh0000_0000, 32'h0, GAIN_ONE}},
      '{ROW_CSR,     skrf_pkg::REG_MEAS_NOISE, 32'h0000_0003, '0},
      '{ROW_ITEM,    skrf_pkg::REG_MEAS_NOISE, 32'h0000_0003, '0},
      '{ROW_CSR,     skrf_pkg::REG_MEAS_NOISE, skrf_pkg::MEAS_NOISE_RST, '0},
      '{ROW_CSR,     skrf_pkg::REG_PROC_NOISE, skrf_pkg::PROC_NOISE_RST, '0},
      '{ROW_ITEM,    skrf_pkg::REG_MEAS_NOISE, 32'h0001_0000, '0},
      '{ROW_ITEM,    skrf_pkg::REG_MEAS_NOISE, 32'hFFFF_0000, '0},
      '{ROW_ITEM,    skrf_pkg::REG_MEAS_NOISE, 32'h7FFF_FFFF, '0},
      '{ROW_ITEM,    skrf_pkg::REG_MEAS_NOISE, 32'h8000_0000, '0},
      '{ROW_ITEM,    skrf_pkg::REG_MEAS_NOISE, 32'h5555_5555, '0},
      '{ROW_ITEM,    skrf_pkg::REG_MEAS_NOISE, 32'hAAAA_AAAA, '0}
   };

   scalar_kalman_rate_filter_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_raw_rate       (req_raw_rate),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_filtered_rate  (rsp_filtered_rate),
      .rsp_error_variance (rsp_error_variance),
      .rsp_kalman_gain    (rsp_kalman_gain),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // One filter step: predict, gain, then estimate and variance update
   function automatic filt_out_type kalman_step(
         input logic signed [skrf_pkg::RATE_W-1:0] raw);
      longint unsigned half_g = ONE_G >> 1;
      longint unsigned pp, den, k, mag, pn;
      longint z, d, nxt;
      filt_out_type o;
      if (!started_st) begin
         est_st = longint'($signed(shadow_cfg.init_est));
         pvar_st = shadow_cfg.init_var;
         started_st = 1'b1;
      end
      // negating the most negative sample saturates
      z = -longint'(raw);
      if (z > S32_MAX) z = S32_MAX;
      pp = 64'(pvar_st) + 64'(shadow_cfg.proc_noise);
      if (pp > 64'hFFFF_FFFF) pp = 64'hFFFF_FFFF;
      den = pp + 64'(shadow_cfg.meas_noise);
      k = (den == 0) ? 64'd0 : (pp << GAIN_FRAC) / den;
      if (k > ONE_G) k = ONE_G;
      d = z - est_st;
      mag = (d < 0) ? -d : d;
      // round half away from zero on the magnitude
      mag = (mag * k + half_g) >> GAIN_FRAC;
      if (d < 0) nxt = est_st - longint'(mag);
      else nxt = est_st + longint'(mag);
      if (nxt > S32_MAX) nxt = S32_MAX;
      if (nxt < S32_MIN) nxt = S32_MIN;
      est_st = nxt;
      pn = ((ONE_G - k) * pp + half_g) >> GAIN_FRAC;
      if (pn > 64'hFFFF_FFFF) pn = 64'hFFFF_FFFF;
      pvar_st = pn[skrf_pkg::VAR_W-1:0];
      o.rate = est_st[skrf_pkg::RATE_W-1:0];
      o.variance = pvar_st;
      o.gain = k[skrf_pkg::GAIN_OUT_W-1:0];
      return o;
   endfunction

   function automatic logic signed [skrf_pkg::RATE_W-1:0] pick_rate(input int centre);
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return centre + int'($urandom_range(0, 8191)) - 4096;
         4, 5, 6, 9: return $urandom();
         7: return int'($urandom_range(0, 65535)) - 32768;
         default: begin
            case ($urandom_range(0, 4))
               0: return 32'sh8000_0000;
               1: return 32'sh7FFF_FFFF;
               2: return 32'sh0000_0000;
               3: return -32'sd1;
               default: return 32'sd1;
            endcase
         end
      endcase
   endfunction

   function automatic int sender_gap();
      int r = $urandom_range(0, 19);
      if (r < 12) return 0;
      if (r < 18) return $urandom_range(1, 4);
      return $urandom_range(20, 60);
   endfunction

   // Leaves req_valid high; the caller lowers it if a gap follows
   task automatic send_rate(input logic signed [skrf_pkg::RATE_W-1:0] raw, input bit typed,
                            input filt_out_type want);
      filt_out_type pred;
      req_valid <= 1'b1;
      req_raw_rate <= raw;
      do @(posedge clock); while (req_stall);
      pred = kalman_step(raw);
      rate_estimates_q.insert(rate_estimates_q.size(), typed ? want : pred);
   endtask

   task automatic idle_sender(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (rate_estimates_q.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(input skrf_pkg::reg_idx_type idx, input logic [31:0] value);
      wait_drained();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      case (idx)
         skrf_pkg::REG_MEAS_NOISE: shadow_cfg.meas_noise = value;
         skrf_pkg::REG_PROC_NOISE: shadow_cfg.proc_noise = value;
         skrf_pkg::REG_INIT_EST:   shadow_cfg.init_est = value;
         skrf_pkg::REG_INIT_VAR:   shadow_cfg.init_var = value;
         default: ;
      endcase
   endtask

   // Receiver: alternating free and stalled stretches, mostly short
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if (rsp_stall) begin
         rsp_stall <= 1'b0;
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(0, 12);
      end else begin
         rsp_stall <= 1'b1;
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                  : $urandom_range(0, 3);
      end
   end

   always @(posedge clock) begin
      filt_out_type exp_o;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rate_estimates_q.size() == 0) begin
            $error("unexpected item: filtered_rate %0d", rsp_filtered_rate);
            fail_count++;
         end else begin
            exp_o = rate_estimates_q.pop_front();
            if (rsp_filtered_rate !== exp_o.rate) begin
               $error("filtered_rate: expected %0d, got %0d", exp_o.rate, rsp_filtered_rate);
               fail_count++;
            end
            if (rsp_error_variance !== exp_o.variance) begin
               $error("error_variance: expected %0d, got %0d", exp_o.variance,
                      rsp_error_variance);
               fail_count++;
            end
            if (rsp_kalman_gain !== exp_o.gain) begin
               $error("kalman_gain: expected %0d, got %0d", exp_o.gain, rsp_kalman_gain);
               fail_count++;
            end
         end
      end
   end

   initial begin
      dir_row_type row;
      logic [31:0] r_val, q_val;
      int centre;
      bit gap_free;
      shadow_cfg = '{skrf_pkg::MEAS_NOISE_RST, skrf_pkg::PROC_NOISE_RST,
                     skrf_pkg::INIT_EST_RST, skrf_pkg::INIT_VAR_RST};
      est_st = 0;
      pvar_st = '0;
      started_st = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_steps[i]) begin
         row = dir_steps[i];
         if (row.kind == ROW_CSR) write_reg(row.idx, row.data);
         else send_rate(row.data, row.kind == ROW_CHECKED, row.want);
      end

      // x0 and P0 writes from here on must have no effect
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         case (ph % 8)
            0: begin r_val = skrf_pkg::MEAS_NOISE_RST; q_val = skrf_pkg::PROC_NOISE_RST; end
            1: begin r_val = '0; q_val = $urandom_range(0, 32'h00FF_FFFF); end
            2: begin r_val = '1; q_val = '1; end
            3: begin r_val = '1; q_val = '0; end
            4: begin r_val = $urandom(); q_val = $urandom(); end
            5: begin r_val = '0; q_val = '0; end
            6: begin
               r_val = $urandom_range(0, 32'h0100_0000);
               q_val = $urandom_range(0, 32'h0001_0000);
            end
            default: begin r_val = 32'd1; q_val = '1; end
         endcase
         write_reg(skrf_pkg::REG_MEAS_NOISE, r_val);
         write_reg(skrf_pkg::REG_PROC_NOISE, q_val);
         write_reg(skrf_pkg::REG_INIT_EST, $urandom());
         write_reg(skrf_pkg::REG_INIT_VAR, $urandom());
         gap_free = ($urandom_range(0, 3) == 0);
         centre = int'($urandom_range(0, 32'h7FFF_FFFF)) - 32'sh4000_0000;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            send_rate(pick_rate(centre), 1'b0, '0);
            if ($urandom_range(0, 99) == 0) wait_drained();
            else if (!gap_free) idle_sender(sender_gap());
         end
      end

      wait_drained();
      repeat (GAIN_FRAC + 10) @(posedge clock);
      if (fail_count == 0 && rate_estimates_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
